>>> rtl/core/ray_pair_crossing_in_window_core_macros.svh
// assertion macros for the ray pair crossing core and its checker
// no dependencies; the including file provides clk and rst_n
`ifndef RAY_PAIR_CROSSING_IN_WINDOW_CORE_MACROS_SVH
`define RAY_PAIR_CROSSING_IN_WINDOW_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RPCIW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define RPCIW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rpciw_pkg.sv
// shared constants and types for the ray pair crossing core
// no dependencies
package rpciw_pkg;

    // register stages from input acceptance to the output register, inclusive
    localparam int PIPE_STAGES = 7;

    // result stream width: one flag padded to a byte
    localparam int OUT_TDATA_BITS = 8;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_WINDOW_LOW  = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_WINDOW_HIGH = cfg_idx_t'(1);

    // window reset values, cut to the coordinate width at the use site
    localparam logic [63:0] WINDOW_LOW_RESET  = 64'd200000000000000;
    localparam logic [63:0] WINDOW_HIGH_RESET = 64'd400000000000000;

endpackage

>>> rtl/core/ray_pair_crossing_in_window_core.sv
// ray pair crossing test against a square window, streaming top level
// depends on rpciw_pkg
//
// Each input transaction carries two 2D rays (start point and velocity). The
// block answers whether their lines meet at one point that both rays reach at
// time zero or later and that lies inside [window_low, window_high] on both
// axes, bounds included. The test is exact integer arithmetic: cross products
// replace the division, and the window test compares scaled sums instead of
// the crossing point itself. Parallel or degenerate rays (zero determinant)
// give 0, as does an inverted window. One pair is accepted per clock unless a
// stalled output has backed up to the input; each pair gives one result
// transaction through the seven register stages of the multiply and compare
// pipeline, the last of which is the output register. A stalled output backs
// the pipeline up stage by stage, so empty stages still fill while a result
// waits. The user must write window registers through the cfg port only while no pair is in flight; not enforced.
module ray_pair_crossing_in_window_core
    import rpciw_pkg::*;
#(
    parameter int COORD_BITS = 50,
    parameter int VEL_BITS   = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [COORD_BITS-1:0] cfg_wdata,
    // ray pair stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // low to high: first_pos_x, first_pos_y, first_vel_x, first_vel_y,
    // second_pos_x, second_pos_y, second_vel_x, second_vel_y, zero pad to bytes
    input  logic [8*((4*(COORD_BITS+VEL_BITS)+7)/8)-1:0] s_tdata,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // low to high: crosses_in_window, zero pad
    output logic [OUT_TDATA_BITS-1:0] m_tdata
);

    localparam int CW = COORD_BITS;
    localparam int VW = VEL_BITS;
    // coordinate difference, velocity product, determinant, cross numerator
    localparam int DW  = CW + 1;
    localparam int PVW = 2 * VW;
    localparam int PW  = DW + VW;
    localparam int TW  = 2 * VW + 1;
    localparam int NW  = CW + VW + 2;
    // window test sums
    localparam int SW  = CW + 2 * VW + 3;
    // split points of the wide multiplies
    localparam int LA = DW / 2;
    localparam int HA = DW - LA;
    localparam int LB = NW / 2;
    localparam int HB = NW - LB;
    localparam int ELO_W = LA + 1 + TW;
    localparam int EHI_W = HA + TW;
    localparam int NLO_W = LB + 1 + VW;
    localparam int NHI_W = HB + VW;
    // input field offsets
    localparam int OFS_P1X = 0;
    localparam int OFS_P1Y = CW;
    localparam int OFS_V1X = 2 * CW;
    localparam int OFS_V1Y = 2 * CW + VW;
    localparam int OFS_P2X = 2 * CW + 2 * VW;
    localparam int OFS_P2Y = 3 * CW + 2 * VW;
    localparam int OFS_V2X = 4 * CW + 2 * VW;
    localparam int OFS_V2Y = 4 * CW + 3 * VW;

    // window registers
    logic signed [CW-1:0] win_low_reg;
    logic signed [CW-1:0] win_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_low_reg  <= WINDOW_LOW_RESET[CW-1:0];
            win_high_reg <= WINDOW_HIGH_RESET[CW-1:0];
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LOW:  win_low_reg  <= cfg_wdata;
                CFG_WINDOW_HIGH: win_high_reg <= cfg_wdata;
                default:         win_low_reg  <= win_low_reg;
            endcase
        end
    end

    // stage valid bits and per-stage advance
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] stage_en;

    always_comb
    begin
        stage_en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || m_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next = (stage_en & {valid_reg[PIPE_STAGES-2:0], s_tvalid})
                   | (~stage_en & valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];

    // input field unpack
    logic signed [CW-1:0] in_p1x, in_p1y, in_p2x, in_p2y;
    logic signed [VW-1:0] in_v1x, in_v1y, in_v2x, in_v2y;

    assign in_p1x = $signed(s_tdata[OFS_P1X +: CW]);
    assign in_p1y = $signed(s_tdata[OFS_P1Y +: CW]);
    assign in_v1x = $signed(s_tdata[OFS_V1X +: VW]);
    assign in_v1y = $signed(s_tdata[OFS_V1Y +: VW]);
    assign in_p2x = $signed(s_tdata[OFS_P2X +: CW]);
    assign in_p2y = $signed(s_tdata[OFS_P2Y +: CW]);
    assign in_v2x = $signed(s_tdata[OFS_V2X +: VW]);
    assign in_v2y = $signed(s_tdata[OFS_V2Y +: VW]);

    // stage 1: point differences, window offsets, determinant products
    // window offsets: 0 x-low, 1 y-low, 2 x-high, 3 y-high
    logic signed [DW-1:0]  dx_s1_next, dy_s1_next;
    logic signed [DW-1:0]  e_s1_next [4];
    logic signed [PVW-1:0] da_s1_next, db_s1_next;
    logic signed [DW-1:0]  dx_s1_reg, dy_s1_reg;
    logic signed [DW-1:0]  e_s1_reg [4];
    logic signed [PVW-1:0] da_s1_reg, db_s1_reg;
    logic signed [VW-1:0]  vel1_s1_reg [2];
    logic signed [VW-1:0]  vel2_s1_reg [2];

    assign dx_s1_next   = DW'(in_p2x) - DW'(in_p1x);
    assign dy_s1_next   = DW'(in_p2y) - DW'(in_p1y);
    assign e_s1_next[0] = DW'(in_p1x) - DW'(win_low_reg);
    assign e_s1_next[1] = DW'(in_p1y) - DW'(win_low_reg);
    assign e_s1_next[2] = DW'(in_p1x) - DW'(win_high_reg);
    assign e_s1_next[3] = DW'(in_p1y) - DW'(win_high_reg);
    assign da_s1_next   = PVW'(in_v1x) * PVW'(in_v2y);
    assign db_s1_next   = PVW'(in_v1y) * PVW'(in_v2x);

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            dx_s1_reg      <= dx_s1_next;
            dy_s1_reg      <= dy_s1_next;
            e_s1_reg       <= e_s1_next;
            da_s1_reg      <= da_s1_next;
            db_s1_reg      <= db_s1_next;
            vel1_s1_reg[0] <= in_v1x;
            vel1_s1_reg[1] <= in_v1y;
            vel2_s1_reg[0] <= in_v2x;
            vel2_s1_reg[1] <= in_v2y;
        end
    end

    // stage 2: determinant, cross numerator products
    logic signed [TW-1:0] det_s2_next;
    logic signed [PW-1:0] pa_s2_next, pb_s2_next, pc_s2_next, pd_s2_next;
    logic signed [TW-1:0] det_s2_reg;
    logic signed [PW-1:0] pa_s2_reg, pb_s2_reg, pc_s2_reg, pd_s2_reg;
    logic signed [DW-1:0] e_s2_reg [4];
    logic signed [VW-1:0] vel1_s2_reg [2];

    assign det_s2_next = TW'(da_s1_reg) - TW'(db_s1_reg);
    assign pa_s2_next  = PW'(dx_s1_reg) * PW'(vel2_s1_reg[1]);
    assign pb_s2_next  = PW'(dy_s1_reg) * PW'(vel2_s1_reg[0]);
    assign pc_s2_next  = PW'(dx_s1_reg) * PW'(vel1_s1_reg[1]);
    assign pd_s2_next  = PW'(dy_s1_reg) * PW'(vel1_s1_reg[0]);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            det_s2_reg  <= det_s2_next;
            pa_s2_reg   <= pa_s2_next;
            pb_s2_reg   <= pb_s2_next;
            pc_s2_reg   <= pc_s2_next;
            pd_s2_reg   <= pd_s2_next;
            e_s2_reg    <= e_s1_reg;
            vel1_s2_reg <= vel1_s1_reg;
        end
    end

    // stage 3: time numerators for both rays
    logic signed [NW-1:0] nt_s3_next, ns_s3_next;
    logic signed [NW-1:0] nt_s3_reg, ns_s3_reg;
    logic signed [TW-1:0] det_s3_reg;
    logic signed [DW-1:0] e_s3_reg [4];
    logic signed [VW-1:0] vel1_s3_reg [2];

    assign nt_s3_next = NW'(pa_s2_reg) - NW'(pb_s2_reg);
    assign ns_s3_next = NW'(pc_s2_reg) - NW'(pd_s2_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            nt_s3_reg   <= nt_s3_next;
            ns_s3_reg   <= ns_s3_next;
            det_s3_reg  <= det_s2_reg;
            e_s3_reg    <= e_s2_reg;
            vel1_s3_reg <= vel1_s2_reg;
        end
    end

    // stage 4: make the determinant positive, check it nonzero and both times non-negative
    logic                 det_neg;
    logic signed [NW-1:0] ns_norm;
    logic signed [TW-1:0] det_s4_next;
    logic signed [NW-1:0] nt_s4_next;
    logic                 ok_s4_next;
    logic signed [TW-1:0] det_s4_reg;
    logic signed [NW-1:0] nt_s4_reg;
    logic                 ok_s4_reg;
    logic signed [DW-1:0] e_s4_reg [4];
    logic signed [VW-1:0] vel1_s4_reg [2];

    assign det_neg     = det_s3_reg[TW-1];
    assign det_s4_next = det_neg ? -det_s3_reg : det_s3_reg;
    assign nt_s4_next  = det_neg ? -nt_s3_reg : nt_s3_reg;
    assign ns_norm     = det_neg ? -ns_s3_reg : ns_s3_reg;
    assign ok_s4_next  = (det_s3_reg != '0) && !nt_s4_next[NW-1] && !ns_norm[NW-1];

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            det_s4_reg  <= det_s4_next;
            nt_s4_reg   <= nt_s4_next;
            ok_s4_reg   <= ok_s4_next;
            e_s4_reg    <= e_s3_reg;
            vel1_s4_reg <= vel1_s3_reg;
        end
    end

    // stage 5: split partial products of offset*det and vel*nt
    logic signed [ELO_W-1:0] elo_s5_next [4];
    logic signed [EHI_W-1:0] ehi_s5_next [4];
    logic signed [NLO_W-1:0] vlo_s5_next [2];
    logic signed [NHI_W-1:0] vhi_s5_next [2];
    logic signed [ELO_W-1:0] elo_s5_reg [4];
    logic signed [EHI_W-1:0] ehi_s5_reg [4];
    logic signed [NLO_W-1:0] vlo_s5_reg [2];
    logic signed [NHI_W-1:0] vhi_s5_reg [2];
    logic                    ok_s5_reg;

    for (genvar i = 0; i < 4; i++)
    begin : g_epart
        assign elo_s5_next[i] = ELO_W'($signed({1'b0, e_s4_reg[i][LA-1:0]}))
                              * ELO_W'(det_s4_reg);
        assign ehi_s5_next[i] = EHI_W'($signed(e_s4_reg[i][DW-1:LA]))
                              * EHI_W'(det_s4_reg);
    end

    for (genvar j = 0; j < 2; j++)
    begin : g_vpart
        assign vlo_s5_next[j] = NLO_W'($signed({1'b0, nt_s4_reg[LB-1:0]}))
                              * NLO_W'(vel1_s4_reg[j]);
        assign vhi_s5_next[j] = NHI_W'($signed(nt_s4_reg[NW-1:LB]))
                              * NHI_W'(vel1_s4_reg[j]);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            elo_s5_reg <= elo_s5_next;
            ehi_s5_reg <= ehi_s5_next;
            vlo_s5_reg <= vlo_s5_next;
            vhi_s5_reg <= vhi_s5_next;
            ok_s5_reg  <= ok_s4_reg;
        end
    end

    // stage 6: recombine partial products
    logic signed [SW-1:0] eprod_s6_next [4];
    logic signed [SW-1:0] vprod_s6_next [2];
    logic signed [SW-1:0] eprod_s6_reg [4];
    logic signed [SW-1:0] vprod_s6_reg [2];
    logic                 ok_s6_reg;

    for (genvar i = 0; i < 4; i++)
    begin : g_ecomb
        assign eprod_s6_next[i] = (SW'(ehi_s5_reg[i]) <<< LA) + SW'(elo_s5_reg[i]);
    end

    for (genvar j = 0; j < 2; j++)
    begin : g_vcomb
        assign vprod_s6_next[j] = (SW'(vhi_s5_reg[j]) <<< LB) + SW'(vlo_s5_reg[j]);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            eprod_s6_reg <= eprod_s6_next;
            vprod_s6_reg <= vprod_s6_next;
            ok_s6_reg    <= ok_s5_reg;
        end
    end

    // stage 7: window sums against zero, into the output register
    // low sides must be >= 0, high sides <= 0
    logic signed [SW-1:0] wsum [4];
    logic                 cross_next;
    logic                 cross_reg;

    for (genvar i = 0; i < 4; i++)
    begin : g_wsum
        assign wsum[i] = eprod_s6_reg[i] + vprod_s6_reg[i % 2];
    end

    assign cross_next = ok_s6_reg
                     && !wsum[0][SW-1] && !wsum[1][SW-1]
                     && (wsum[2][SW-1] || (wsum[2] == '0))
                     && (wsum[3][SW-1] || (wsum[3] == '0));

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            cross_reg <= cross_next;
        end
    end

    assign m_tvalid = valid_reg[PIPE_STAGES-1];
    assign m_tdata  = OUT_TDATA_BITS'(cross_reg);

endmodule

>>> rtl/core/rpciw_checker.sv
// port-level checker for the ray pair crossing core, bound to the top level
// depends on rpciw_pkg and ray_pair_crossing_in_window_core_macros.svh
`include "ray_pair_crossing_in_window_core_macros.svh"

module rpciw_checker
    import rpciw_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [OUT_TDATA_BITS-1:0] m_tdata
);

    localparam int CNT_BITS = $clog2(PIPE_STAGES + 2);

    // count of accepted pairs whose result is not yet delivered
    logic                s_xfer;
    logic                m_xfer;
    logic [CNT_BITS-1:0] inflight_reg;
    logic [CNT_BITS-1:0] inflight_next;

    assign s_xfer        = s_tvalid && s_tready;
    assign m_xfer        = m_tvalid && m_tready;
    assign inflight_next = inflight_reg + CNT_BITS'(s_xfer) - CNT_BITS'(m_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // a stalled result holds its value
    `RPCIW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")

    // with the output register empty the whole pipeline can advance
    `RPCIW_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input not ready with output empty")

    // never more pairs in flight than pipeline stages
    `RPCIW_ASSERT_NOW(a_inflight_bound, 1'b1,
        inflight_reg <= CNT_BITS'(PIPE_STAGES), "too many pairs in flight")

    // every result belongs to an accepted pair
    `RPCIW_ASSERT_NOW(a_no_invented, m_tvalid, inflight_reg != '0, "result without a pending pair")

endmodule

bind ray_pair_crossing_in_window_core rpciw_checker u_rpciw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
